@@ sv/ncrt_pkg.sv @@
package ncrt_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] node_id;
    logic [7:0]  command;
    logic [31:0] tag;
    logic [7:0]  response;
    logic [4:0]  entry_index;
    logic [31:0] now_time;
    logic        send_ok;
    logic        report_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  result_kind;
    logic [15:0] out_node_id;
    logic [7:0]  out_command;
    logic [31:0] out_tag;
    logic [7:0]  out_response;
  } out_item_t;

  typedef struct packed {
    logic [31:0] heartbeat_interval;
    logic [31:0] offline_probe_interval;
    logic [31:0] command_timeout;
    logic [31:0] heartbeat_retry_wait;
    logic [7:0]  max_retries;
    logic [7:0]  heartbeat_code;
    logic [7:0]  abnormal_code;
    logic [7:0]  motor_running_code;
  } cfg_regs_t;

  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_SEND = 2'd1;
  localparam logic [1:0] REQ_RESP = 2'd2;
  localparam logic [1:0] REQ_SERVICE = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_STANDBY = 2'd1;
  localparam logic [1:0] PH_RUN = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [3:0] RK_NOTHING = 4'd0;
  localparam logic [3:0] RK_OK = 4'd1;
  localparam logic [3:0] RK_NOT_FOUND = 4'd2;
  localparam logic [3:0] RK_BUSY = 4'd3;
  localparam logic [3:0] RK_DISPATCH = 4'd4;
  localparam logic [3:0] RK_REPORT = 4'd5;
  localparam logic [3:0] RK_OFFLINE = 4'd6;
  localparam logic [3:0] RK_ONLINE = 4'd7;
  localparam logic [3:0] RK_FULL = 4'd8;

  localparam logic [2:0] REG_HB_INTERVAL = 3'd0;
  localparam logic [2:0] REG_PROBE_INTERVAL = 3'd1;
  localparam logic [2:0] REG_CMD_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_HB_WAIT = 3'd3;
  localparam logic [2:0] REG_MAX_RETRIES = 3'd4;
  localparam logic [2:0] REG_HB_CODE = 3'd5;
  localparam logic [2:0] REG_ABN_CODE = 3'd6;
  localparam logic [2:0] REG_MOTOR_CODE = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_EVAL,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage

@@ sv/ncrt_cfg.sv @@
module ncrt_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ncrt_pkg::cfg_regs_t regs
);

  ncrt_pkg::cfg_regs_t regs_r;
  logic [2:0] idx;

  assign idx = paddr[4:2];
  assign pready = 1'b1;
  assign regs = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.heartbeat_interval <= 32'd60;
      regs_r.offline_probe_interval <= 32'd600;
      regs_r.command_timeout <= 32'd10;
      regs_r.heartbeat_retry_wait <= 32'd3;
      regs_r.max_retries <= 8'd3;
      regs_r.heartbeat_code <= 8'd1;
      regs_r.abnormal_code <= 8'd2;
      regs_r.motor_running_code <= 8'd3;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        ncrt_pkg::REG_HB_INTERVAL:    regs_r.heartbeat_interval <= pwdata;
        ncrt_pkg::REG_PROBE_INTERVAL: regs_r.offline_probe_interval <= pwdata;
        ncrt_pkg::REG_CMD_TIMEOUT:    regs_r.command_timeout <= pwdata;
        ncrt_pkg::REG_HB_WAIT:        regs_r.heartbeat_retry_wait <= pwdata;
        ncrt_pkg::REG_MAX_RETRIES:    regs_r.max_retries <= pwdata[7:0];
        ncrt_pkg::REG_HB_CODE:        regs_r.heartbeat_code <= pwdata[7:0];
        ncrt_pkg::REG_ABN_CODE:       regs_r.abnormal_code <= pwdata[7:0];
        default:                      regs_r.motor_running_code <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ncrt_pkg::REG_HB_INTERVAL:    prdata = regs_r.heartbeat_interval;
      ncrt_pkg::REG_PROBE_INTERVAL: prdata = regs_r.offline_probe_interval;
      ncrt_pkg::REG_CMD_TIMEOUT:    prdata = regs_r.command_timeout;
      ncrt_pkg::REG_HB_WAIT:        prdata = regs_r.heartbeat_retry_wait;
      ncrt_pkg::REG_MAX_RETRIES:    prdata = {24'd0, regs_r.max_retries};
      ncrt_pkg::REG_HB_CODE:        prdata = {24'd0, regs_r.heartbeat_code};
      ncrt_pkg::REG_ABN_CODE:       prdata = {24'd0, regs_r.abnormal_code};
      default:                      prdata = {24'd0, regs_r.motor_running_code};
    endcase
  end

endmodule

@@ sv/node_command_retry_table_unit.sv @@
// Node command/retry table. Holds up to MAX_NODES radio nodes in a slot
// memory (one record per slot, one read and one write port) plus a valid
// bit per slot. Add, send and response requests search the table one slot
// per cycle. A service request reads its slot directly, and a service of
// an empty slot gives its result without a memory read. The block takes
// one item at a time. in_stall is high while an item is at work or its
// result still waits in the output register. The next item is taken no
// earlier than the cycle after the result leaves.
module node_command_retry_table_unit #(
  parameter int MAX_NODES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ncrt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ncrt_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  // one slot record
  typedef struct packed {
    logic [15:0] node_id;
    logic [1:0]  phase;
    logic [7:0]  command;
    logic [31:0] tag;
    logic [7:0]  response;
    logic [7:0]  retries;
    logic        online;
    logic [31:0] last_time;
  } slot_t;

  ncrt_pkg::cfg_regs_t cfg;

  ncrt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (cfg)
  );

  slot_t mem [MAX_NODES];
  slot_t rd_r;
  logic [MAX_NODES-1:0] valid_r, valid_nxt;
  logic [CW-1:0] count_r, count_nxt;

  ncrt_pkg::state_t state_r, state_nxt;
  ncrt_pkg::in_item_t item_r, item_nxt;
  ncrt_pkg::out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  // scan pointer and search results
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic found_r, found_nxt;
  logic [AW-1:0] hit_r, hit_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [AW-1:0] free_r, free_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  slot_t wr_data;
  logic new_slot;

  // shared idle-time subtractor for the service compares of the write step
  logic [31:0] idle_time;

  assign in_stall = (state_r != ncrt_pkg::ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = res_r;
  assign idle_time = item_r.now_time - rd_r.last_time;

  // slot memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncrt_pkg::ST_IDLE;
      valid_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt;
    res_r <= res_nxt;
    ptr_r <= ptr_nxt;
    found_r <= found_nxt;
    hit_r <= hit_nxt;
    free_ok_r <= free_ok_nxt;
    free_r <= free_nxt;
    addr_r <= addr_nxt;
  end

  always_comb begin
    slot_t w;
    state_nxt = state_r;
    valid_nxt = valid_r;
    count_nxt = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    item_nxt = item_r;
    res_nxt = res_r;
    ptr_nxt = ptr_r;
    found_nxt = found_r;
    hit_nxt = hit_r;
    free_ok_nxt = free_ok_r;
    free_nxt = free_r;
    addr_nxt = addr_r;
    rd_en = 1'b0;
    rd_addr = ptr_r[AW-1:0];
    wr_en = 1'b0;
    w = rd_r;
    new_slot = 1'b0;
    wr_data = rd_r;

    unique case (state_r)
      ncrt_pkg::ST_IDLE: begin
        if (in_valid && !out_valid_r) begin
          item_nxt = in_data;
          ptr_nxt = '0;
          found_nxt = 1'b0;
          free_ok_nxt = 1'b0;
          res_nxt = '0;
          if (in_data.req_type == ncrt_pkg::REQ_SERVICE) begin
            if ({27'd0, in_data.entry_index} >= 32'(MAX_NODES) ||
                !valid_r[AW'(in_data.entry_index)]) begin
              state_nxt = ncrt_pkg::ST_OUT;
            end else begin
              addr_nxt = AW'(in_data.entry_index);
              state_nxt = ncrt_pkg::ST_READ;
            end
          end else begin
            state_nxt = ncrt_pkg::ST_SCAN;
          end
        end
      end

      // one slot per cycle: read id, compare on the next cycle
      ncrt_pkg::ST_SCAN: begin
        if (ptr_r != '0 && !found_r) begin
          if (valid_r[ptr_r[AW-1:0] - AW'(1)] && rd_r.node_id == item_r.node_id) begin
            found_nxt = 1'b1;
            hit_nxt = ptr_r[AW-1:0] - AW'(1);
          end
          if (!valid_r[ptr_r[AW-1:0] - AW'(1)] && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_nxt = ptr_r[AW-1:0] - AW'(1);
          end
        end
        if (ptr_r == CW'(MAX_NODES)) begin
          state_nxt = ncrt_pkg::ST_READ;
        end else begin
          rd_en = 1'b1;
          rd_addr = ptr_r[AW-1:0];
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      // final compare of the scan, or read of the service target slot
      ncrt_pkg::ST_READ: begin
        if (item_r.req_type != ncrt_pkg::REQ_SERVICE) begin
          if (ptr_r != '0 && !found_r && ptr_r == CW'(MAX_NODES)) begin
            if (valid_r[AW'(MAX_NODES - 1)] && rd_r.node_id == item_r.node_id) begin
              found_nxt = 1'b1;
              hit_nxt = AW'(MAX_NODES - 1);
            end
            if (!valid_r[AW'(MAX_NODES - 1)] && !free_ok_r) begin
              free_ok_nxt = 1'b1;
              free_nxt = AW'(MAX_NODES - 1);
            end
          end
          ptr_nxt = '0;
          state_nxt = ncrt_pkg::ST_EVAL;
        end else begin
          rd_en = 1'b1;
          rd_addr = addr_r;
          state_nxt = ncrt_pkg::ST_WRITE;
        end
      end

      // resolve search: read the hit slot, take a free slot for a new add, or report full or not found
      ncrt_pkg::ST_EVAL: begin
        res_nxt = '0;
        res_nxt.out_node_id = item_r.node_id;
        if (found_r) begin
          addr_nxt = hit_r;
          rd_en = 1'b1;
          rd_addr = hit_r;
          state_nxt = ncrt_pkg::ST_WRITE;
        end else if (item_r.req_type == ncrt_pkg::REQ_ADD) begin
          if (count_r >= CW'(MAX_NODES) || !free_ok_r) begin
            res_nxt.result_kind = ncrt_pkg::RK_FULL;
            state_nxt = ncrt_pkg::ST_OUT;
          end else begin
            addr_nxt = free_r;
            ptr_nxt = CW'(1);
            state_nxt = ncrt_pkg::ST_WRITE;
          end
        end else begin
          res_nxt.result_kind = ncrt_pkg::RK_NOT_FOUND;
          state_nxt = ncrt_pkg::ST_OUT;
        end
      end

      // apply the request to the slot record
      ncrt_pkg::ST_WRITE: begin
        w = rd_r;
        res_nxt = '0;
        new_slot = (item_r.req_type == ncrt_pkg::REQ_ADD) && ptr_r[0] && !found_r;
        state_nxt = ncrt_pkg::ST_OUT;
        unique case (item_r.req_type)
          ncrt_pkg::REQ_ADD: begin
            if (new_slot) begin
              w.node_id = item_r.node_id;
              w.command = '0;
              w.tag = '0;
              w.response = '0;
              valid_nxt[addr_r] = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            w.phase = ncrt_pkg::PH_IDLE;
            w.retries = '0;
            w.online = 1'b1;
            w.last_time = item_r.now_time;
            wr_en = 1'b1;
            res_nxt.result_kind = ncrt_pkg::RK_OK;
            res_nxt.out_node_id = item_r.node_id;
          end
          ncrt_pkg::REQ_SEND: begin
            res_nxt.out_node_id = item_r.node_id;
            if (rd_r.phase != ncrt_pkg::PH_IDLE) begin
              res_nxt.result_kind = ncrt_pkg::RK_BUSY;
              res_nxt.out_tag = item_r.tag;
            end else begin
              w.command = item_r.command;
              w.tag = item_r.tag;
              w.response = '0;
              w.phase = ncrt_pkg::PH_STANDBY;
              wr_en = 1'b1;
              res_nxt.result_kind = ncrt_pkg::RK_OK;
            end
          end
          ncrt_pkg::REQ_RESP: begin
            if (rd_r.command == item_r.command && rd_r.tag == item_r.tag) begin
              w.response = item_r.response;
              w.phase = ncrt_pkg::PH_DONE;
              wr_en = 1'b1;
              res_nxt.result_kind = ncrt_pkg::RK_OK;
              res_nxt.out_node_id = item_r.node_id;
            end else if (item_r.command == cfg.abnormal_code && item_r.tag == '0) begin
              w.command = item_r.command;
              w.response = item_r.response;
              w.phase = ncrt_pkg::PH_DONE;
              wr_en = 1'b1;
              res_nxt.result_kind = ncrt_pkg::RK_OK;
              res_nxt.out_node_id = item_r.node_id;
            end
          end
          default: begin
            wr_en = 1'b1;
            unique case (rd_r.phase)
              ncrt_pkg::PH_IDLE: begin
                if ((rd_r.online && idle_time > cfg.heartbeat_interval) ||
                    (!rd_r.online && idle_time > cfg.offline_probe_interval)) begin
                  w.phase = ncrt_pkg::PH_STANDBY;
                  w.command = cfg.heartbeat_code;
                  w.response = '0;
                  w.tag = '0;
                end
              end
              ncrt_pkg::PH_STANDBY: begin
                if (item_r.send_ok) begin
                  w.phase = ncrt_pkg::PH_RUN;
                  w.last_time = item_r.now_time;
                end
                res_nxt.result_kind = ncrt_pkg::RK_DISPATCH;
                res_nxt.out_node_id = rd_r.node_id;
                res_nxt.out_command = rd_r.command;
                res_nxt.out_tag = rd_r.tag;
              end
              ncrt_pkg::PH_RUN: begin
                if (idle_time >= ((rd_r.command != cfg.heartbeat_code) ?
                                  cfg.command_timeout : cfg.heartbeat_retry_wait)) begin
                  w.phase = ncrt_pkg::PH_STANDBY;
                  w.retries = rd_r.retries + 8'd1;
                  if (w.retries >= cfg.max_retries) begin
                    w.phase = ncrt_pkg::PH_IDLE;
                    w.retries = '0;
                    w.online = 1'b0;
                    if (rd_r.online) begin
                      res_nxt.result_kind = ncrt_pkg::RK_OFFLINE;
                      res_nxt.out_node_id = rd_r.node_id;
                    end
                  end
                end
              end
              default: begin
                w.last_time = item_r.now_time;
                if (rd_r.command != cfg.heartbeat_code) begin
                  if (item_r.report_ok) begin
                    if (rd_r.response == cfg.motor_running_code) begin
                      w.phase = ncrt_pkg::PH_RUN;
                      w.retries = '0;
                    end else begin
                      w.phase = ncrt_pkg::PH_IDLE;
                      w.tag = '0;
                      w.command = '0;
                      w.response = '0;
                      w.retries = '0;
                    end
                  end
                  res_nxt.result_kind = ncrt_pkg::RK_REPORT;
                  res_nxt.out_node_id = rd_r.node_id;
                  res_nxt.out_command = rd_r.command;
                  res_nxt.out_tag = rd_r.tag;
                  res_nxt.out_response = rd_r.response;
                end else begin
                  w.phase = ncrt_pkg::PH_IDLE;
                  w.tag = '0;
                  w.command = '0;
                  w.response = '0;
                  w.retries = '0;
                  if (!rd_r.online) begin
                    w.online = 1'b1;
                    res_nxt.result_kind = ncrt_pkg::RK_ONLINE;
                    res_nxt.out_node_id = rd_r.node_id;
                  end
                end
              end
            endcase
          end
        endcase
        wr_data = w;
      end

      default: begin
        out_valid_nxt = 1'b1;
        state_nxt = ncrt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ tb/tb_node_command_retry_table_unit.sv @@
`timescale 1ns / 1ps

module tb_node_command_retry_table_unit;
  import ncrt_pkg::*;

  localparam int SLOTS = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  // mirror of the node table plus the expected result stream
  class retry_table_sb;
    bit          sl_valid[SLOTS];
    logic [15:0] sl_id[SLOTS];
    logic [1:0]  sl_phase[SLOTS];
    logic [7:0]  sl_cmd[SLOTS];
    logic [31:0] sl_tag[SLOTS];
    logic [7:0]  sl_resp[SLOTS];
    logic [7:0]  sl_retry[SLOTS];
    bit          sl_online[SLOTS];
    logic [31:0] sl_last[SLOTS];
    int          sl_count;
    logic [31:0] hb_int, probe_int, cmd_to, hb_wait;
    logic [7:0]  max_retry, hb_code, abn_code, motor_code;
    out_item_t   pending_results[$];
    int          errors;

    function new();
      for (int i = 0; i < SLOTS; i++) sl_valid[i] = 0;
      sl_count = 0;
      hb_int = 60; probe_int = 600; cmd_to = 10; hb_wait = 3;
      max_retry = 3; hb_code = 1; abn_code = 2; motor_code = 3;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_HB_INTERVAL:    hb_int = v;
        REG_PROBE_INTERVAL: probe_int = v;
        REG_CMD_TIMEOUT:    cmd_to = v;
        REG_HB_WAIT:        hb_wait = v;
        REG_MAX_RETRIES:    max_retry = v[7:0];
        REG_HB_CODE:        hb_code = v[7:0];
        REG_ABN_CODE:       abn_code = v[7:0];
        default:            motor_code = v[7:0];
      endcase
    endfunction

    function int find(logic [15:0] id);
      for (int i = 0; i < SLOTS; i++)
        if (sl_valid[i] && sl_id[i] == id) return i;
      return -1;
    endfunction

    function out_item_t mk(logic [3:0] k, logic [15:0] id, logic [7:0] c,
                           logic [31:0] t, logic [7:0] r);
      out_item_t o;
      o.result_kind = k; o.out_node_id = id; o.out_command = c;
      o.out_tag = t; o.out_response = r;
      return o;
    endfunction

    function void clear_cmd(int s);
      sl_phase[s] = PH_IDLE; sl_tag[s] = 0; sl_cmd[s] = 0;
      sl_resp[s] = 0; sl_retry[s] = 0;
    endfunction

    function out_item_t predict(in_item_t it);
      int s;
      int i;
      logic [31:0] lim;
      logic [7:0] r;
      bit was_on;
      s = find(it.node_id);
      case (it.req_type)
        REQ_ADD: begin
          if (s < 0) begin
            if (sl_count >= SLOTS) return mk(RK_FULL, it.node_id, 0, 0, 0);
            for (i = 0; i < SLOTS; i++)
              if (!sl_valid[i]) break;
            s = i;
            sl_valid[s] = 1; sl_id[s] = it.node_id;
            clear_cmd(s);
            sl_count++;
          end
          sl_phase[s] = PH_IDLE; sl_retry[s] = 0; sl_online[s] = 1;
          sl_last[s] = it.now_time;
          return mk(RK_OK, it.node_id, 0, 0, 0);
        end
        REQ_SEND: begin
          if (s < 0) return mk(RK_NOT_FOUND, it.node_id, 0, 0, 0);
          if (sl_phase[s] != PH_IDLE) return mk(RK_BUSY, it.node_id, 0, it.tag, 0);
          sl_cmd[s] = it.command; sl_tag[s] = it.tag; sl_resp[s] = 0;
          sl_phase[s] = PH_STANDBY;
          return mk(RK_OK, it.node_id, 0, 0, 0);
        end
        REQ_RESP: begin
          if (s < 0) return mk(RK_NOT_FOUND, it.node_id, 0, 0, 0);
          if (sl_cmd[s] == it.command && sl_tag[s] == it.tag) begin
            sl_resp[s] = it.response; sl_phase[s] = PH_DONE;
          end else if (it.command == abn_code && it.tag == 0) begin
            sl_cmd[s] = it.command; sl_resp[s] = it.response; sl_phase[s] = PH_DONE;
          end else begin
            return mk(RK_NOTHING, 0, 0, 0, 0);
          end
          return mk(RK_OK, it.node_id, 0, 0, 0);
        end
        default: begin
          s = int'(it.entry_index);
          if (!sl_valid[s]) return mk(RK_NOTHING, 0, 0, 0, 0);
          case (sl_phase[s])
            PH_IDLE: begin
              lim = sl_online[s] ? hb_int : probe_int;
              if (it.now_time - sl_last[s] > lim) begin
                sl_phase[s] = PH_STANDBY; sl_cmd[s] = hb_code;
                sl_resp[s] = 0; sl_tag[s] = 0;
              end
              return mk(RK_NOTHING, 0, 0, 0, 0);
            end
            PH_STANDBY: begin
              out_item_t o;
              o = mk(RK_DISPATCH, sl_id[s], sl_cmd[s], sl_tag[s], 0);
              if (it.send_ok) begin
                sl_phase[s] = PH_RUN; sl_last[s] = it.now_time;
              end
              return o;
            end
            PH_RUN: begin
              lim = (sl_cmd[s] != hb_code) ? cmd_to : hb_wait;
              if (it.now_time - sl_last[s] >= lim) begin
                sl_phase[s] = PH_STANDBY;
                sl_retry[s] = sl_retry[s] + 8'd1;
                if (sl_retry[s] >= max_retry) begin
                  was_on = sl_online[s];
                  sl_phase[s] = PH_IDLE; sl_retry[s] = 0; sl_online[s] = 0;
                  if (was_on) return mk(RK_OFFLINE, sl_id[s], 0, 0, 0);
                end
              end
              return mk(RK_NOTHING, 0, 0, 0, 0);
            end
            default: begin
              out_item_t o;
              sl_last[s] = it.now_time;
              if (sl_cmd[s] != hb_code) begin
                r = sl_resp[s];
                o = mk(RK_REPORT, sl_id[s], sl_cmd[s], sl_tag[s], r);
                if (it.report_ok) begin
                  if (r == motor_code) begin
                    sl_phase[s] = PH_RUN; sl_retry[s] = 0;
                  end else begin
                    clear_cmd(s);
                  end
                end
                return o;
              end
              clear_cmd(s);
              if (!sl_online[s]) begin
                sl_online[s] = 1;
                return mk(RK_ONLINE, sl_id[s], 0, 0, 0);
              end
              return mk(RK_NOTHING, 0, 0, 0, 0);
            end
          endcase
        end
      endcase
    endfunction

    function void note_request(in_item_t it);
      pending_results.push_back(predict(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result kind %0d", got.result_kind);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.result_kind !== e.result_kind) begin
        $error("result_kind exp %0d got %0d", e.result_kind, got.result_kind); errors++;
      end
      if (got.out_node_id !== e.out_node_id) begin
        $error("out_node_id exp %h got %h", e.out_node_id, got.out_node_id); errors++;
      end
      if (got.out_command !== e.out_command) begin
        $error("out_command exp %h got %h", e.out_command, got.out_command); errors++;
      end
      if (got.out_tag !== e.out_tag) begin
        $error("out_tag exp %h got %h", e.out_tag, got.out_tag); errors++;
      end
      if (got.out_response !== e.out_response) begin
        $error("out_response exp %h got %h", e.out_response, got.out_response); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  retry_table_sb sb;
  logic [31:0]   rtc;          // running rtc seconds fed into items
  logic [15:0]   id_pool[40];  // 40 ids so the table eventually fills
  bit            no_idle;      // stretches without gaps or stalls
  int            quiet_cnt;

  node_command_retry_table_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stall pattern
  initial begin
    int left;
    out_stall = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left > 0) begin
        left--;
      end else begin
        left = pick_gap();
        out_stall <= (left > 0);
      end
    end
  end

  // check every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // watchdog on cycles where neither channel moves an item
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // present one item, hold it until accepted, then record its expectation
  task automatic push_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(it);
  endtask

  // let every expected result drain, then give the block time to settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // two-phase register write, only called while the block is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_pready) break;
    end
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] hb, logic [31:0] pr, logic [31:0] to,
                           logic [31:0] hw, logic [7:0] mr, logic [7:0] hc,
                           logic [7:0] ac, logic [7:0] mc);
    write_reg(REG_HB_INTERVAL, hb);
    write_reg(REG_PROBE_INTERVAL, pr);
    write_reg(REG_CMD_TIMEOUT, to);
    write_reg(REG_HB_WAIT, hw);
    write_reg(REG_MAX_RETRIES, {24'd0, mr});
    write_reg(REG_HB_CODE, {24'd0, hc});
    write_reg(REG_ABN_CODE, {24'd0, ac});
    write_reg(REG_MOTOR_CODE, {24'd0, mc});
  endtask

  // directed item, rtc moves forward by dt first
  task automatic send_req(logic [1:0] rq, logic [15:0] id, logic [7:0] c,
                          logic [31:0] t, logic [7:0] r, logic [4:0] idx,
                          logic [31:0] dt, bit sok, bit rok);
    in_item_t it;
    rtc = rtc + dt;
    it.req_type = rq; it.node_id = id; it.command = c; it.tag = t;
    it.response = r; it.entry_index = idx; it.now_time = rtc;
    it.send_ok = sok; it.report_ok = rok;
    push_item(it);
  endtask

  // random item, mostly pool ids; responses often carry the stored command and tag
  task automatic push_random();
    in_item_t it;
    int s;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) rtc = $urandom();
    else if (r < 10) rtc = rtc + $urandom_range(50, 800);
    else rtc = rtc + $urandom_range(0, 15);
    it.now_time = rtc;
    it.node_id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, 39)]
                                                : 16'($urandom());
    it.command = 8'($urandom());
    it.tag = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
    it.response = ($urandom_range(0, 2) == 0) ? sb.motor_code : 8'($urandom());
    it.entry_index = 5'($urandom());
    it.send_ok = $urandom_range(0, 3) != 0;
    it.report_ok = $urandom_range(0, 3) != 0;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      it.req_type = REQ_ADD;
    end else if (r < 35) begin
      it.req_type = REQ_SEND;
      if ($urandom_range(0, 9) == 0) it.command = sb.hb_code;
    end else if (r < 55) begin
      it.req_type = REQ_RESP;
      s = sb.find(it.node_id);
      r = $urandom_range(0, 99);
      if (s >= 0 && r < 60) begin
        it.command = sb.sl_cmd[s]; it.tag = sb.sl_tag[s];
      end else if (r < 80) begin
        it.command = sb.abn_code; it.tag = 0;
      end
    end else begin
      it.req_type = REQ_SERVICE;
      if ($urandom_range(0, 99) < 80 && sb.sl_count > 0) begin
        s = $urandom_range(0, SLOTS - 1);
        while (!sb.sl_valid[s]) s = (s + 1) % SLOTS;
        it.entry_index = 5'(s);
      end
    end
    push_item(it);
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      no_idle = (k < 30);
      push_random();
    end
    no_idle = 0;
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
    cfg_paddr = '0; cfg_pwdata = '0;
    no_idle = 0;
    rtc = 32'd100;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 40; i++) id_pool[i] = 16'($urandom());
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    // directed walk through one node's life at reset settings, with a second node and an unknown id
    send_req(REQ_ADD, 16'h0000, 0, 0, 0, 0, 0, 1, 1);
    send_req(REQ_ADD, 16'hFFFF, 0, 0, 0, 0, 0, 1, 1);
    send_req(REQ_ADD, 16'h0000, 0, 0, 0, 0, 1, 1, 1);      // refresh
    send_req(REQ_SEND, 16'h1234, 8'h10, 32'h5, 0, 0, 0, 1, 1);  // unknown id
    send_req(REQ_RESP, 16'h1234, 8'h10, 32'h5, 0, 0, 0, 1, 1);
    send_req(REQ_SEND, 16'h0000, 8'hFF, 32'hFFFFFFFF, 0, 0, 0, 1, 1);
    send_req(REQ_SEND, 16'h0000, 8'h11, 32'h1, 0, 0, 0, 1, 1);  // busy
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 1, 0, 1);      // dispatch, link refused
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 1, 1, 1);      // dispatch, now running
    send_req(REQ_RESP, 16'h0000, 8'h55, 32'h7, 8'h9, 0, 0, 1, 1);  // unmatched
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 5, 1, 1);      // not yet timed out
    send_req(REQ_RESP, 16'h0000, 8'hFF, 32'hFFFFFFFF, 8'd3, 0, 0, 1, 1);  // motor running
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 1, 1, 0);      // report, host refused
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 1, 1, 1);      // report, back to waiting
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 20, 1, 1);     // first retry
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 1, 1, 1);
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 20, 1, 1);     // second retry
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 1, 1, 1);
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 20, 1, 1);     // goes offline
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd31, 0, 1, 1);     // empty slot
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 700, 1, 1);    // offline probe scheduled
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 1, 1, 1);      // heartbeat dispatched
    send_req(REQ_RESP, 16'h0000, 8'd1, 32'd0, 8'h0, 0, 0, 1, 1);
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd0, 1, 1, 1);      // back online
    send_req(REQ_RESP, 16'hFFFF, 8'd2, 32'd0, 8'hAA, 0, 0, 1, 1);  // abnormal report
    send_req(REQ_SERVICE, 0, 0, 0, 0, 5'd1, 1, 1, 1);

    random_phase(120);

    // sender holds off until the table has answered everything
    wait_drained();
    write_all(0, 0, 0, 0, 8'd1, 8'd0, 8'hFF, 8'hFF);
    random_phase(120);

    wait_drained();
    write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
              8'd255, 8'hFF, 8'h00, 8'h00);
    random_phase(120);

    wait_drained();
    write_all($urandom_range(0, 40), $urandom_range(0, 200), $urandom_range(0, 30),
              $urandom_range(0, 10), 8'($urandom_range(1, 5)), 8'($urandom()),
              8'($urandom()), 8'($urandom()));
    random_phase(120);

    wait_drained();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ncrt_pkg.sv
sv/ncrt_cfg.sv
sv/node_command_retry_table_unit.sv
tb/tb_node_command_retry_table_unit.sv
